// ===== hdl/ttcg_pkg.sv =====
package ttcg_pkg;

    // Grid geometry. Each row holds GRID_COLS character cells plus one
    // trailing cell that only ever receives zeros, from row clears and after a character.
    localparam int GRID_COLS  = 40;
    localparam int GRID_ROWS  = 16;
    localparam int COL_W      = $clog2(GRID_COLS + 1);
    localparam int ROW_W      = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int GRID_DEPTH = GRID_ROWS * (2 ** COL_W);

    // Command codes of an input transaction.
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Byte codes the terminal reacts to.
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] PRINT_LO  = 8'd32;
    localparam logic [7:0] PRINT_HI  = 8'd126;

    // Write address selection.
    typedef logic [1:0] wa_sel_t;
    localparam wa_sel_t WA_CURSOR      = 2'd0;
    localparam wa_sel_t WA_CURSOR_LEFT = 2'd1;
    localparam wa_sel_t WA_SWEEP       = 2'd2;
    localparam wa_sel_t WA_INIT        = 2'd3;

    // Cursor column operations.
    typedef logic [1:0] col_op_t;
    localparam col_op_t COL_HOLD = 2'd0;
    localparam col_op_t COL_ZERO = 2'd1;
    localparam col_op_t COL_INC  = 2'd2;
    localparam col_op_t COL_DEC  = 2'd3;

    typedef struct packed {
        logic             cmd;
        logic [7:0]       char_code;
        logic [ROW_W-1:0] read_row;
        logic [COL_W-1:0] read_col;
    } item_t;

    typedef struct packed {
        logic [7:0]       cell_char;
        logic [ROW_W-1:0] cursor_row;
        logic [COL_W-1:0] cursor_col;
    } result_t;

    typedef struct packed {
        logic    load_item;
        logic    wr_en;
        wa_sel_t wr_addr_sel;
        logic    wr_char;
        logic    rd_en;
        col_op_t col_op;
        logic    row_inc;
        logic    scroll;
        logic    sweep_step;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_read;
        logic read_ok;
        logic ch_esc;
        logic ch_lbrack;
        logic ch_cr;
        logic ch_lf;
        logic ch_bs;
        logic ch_print;
        logic ch_csi_end;
        logic col_zero;
        logic col_full;
        logic row_last;
        logic sweep_col_last;
        logic sweep_row_last;
    } dp_stat_t;

endpackage

// ===== hdl/ttcg_datapath.sv =====
module ttcg_datapath
    import ttcg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  item_t     item,
    input  ctrl_cmd_t cmd,
    output dp_stat_t  stat,
    output result_t   result
);

    // Rows are stored in a ring; top_reg is the physical row shown as row 0.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= (ROW_W+1)'(GRID_ROWS))
        begin
            sum = sum - (ROW_W+1)'(GRID_ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    item_t            item_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [ROW_W-1:0] top_reg;
    logic [ROW_W-1:0] top_next;
    logic [COL_W-1:0] clr_col_reg;
    logic [COL_W-1:0] clr_col_next;
    logic [ROW_W-1:0] clr_row_reg;
    logic [ROW_W-1:0] clr_row_next;
    logic [7:0]       rd_data_reg;
    result_t          result_reg;

    logic [7:0]        grid_mem [GRID_DEPTH];
    logic [ROW_W-1:0]  cur_phys;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        wr_data;
    logic [7:0]        code;
    logic [7:0]        rd_cell;

    assign code     = item_reg.char_code;
    assign cur_phys = phys_row(row_reg, top_reg);

    always_comb
    begin
        case (cmd.col_op)
            COL_HOLD: col_next = col_reg;
            COL_ZERO: col_next = '0;
            COL_INC:  col_next = col_reg + 1'b1;
            COL_DEC:  col_next = col_reg - 1'b1;
            default:  col_next = col_reg;
        endcase
    end

    assign row_next = cmd.row_inc ? row_reg + 1'b1 : row_reg;

    always_comb
    begin
        top_next = top_reg;
        if (cmd.scroll)
        begin
            top_next = (top_reg == ROW_W'(GRID_ROWS - 1)) ? '0 : top_reg + 1'b1;
        end
    end

    always_comb
    begin
        clr_col_next = clr_col_reg;
        clr_row_next = clr_row_reg;
        if (cmd.sweep_step)
        begin
            if (clr_col_reg == COL_W'(GRID_COLS))
            begin
                clr_col_next = '0;
                clr_row_next = (clr_row_reg == ROW_W'(GRID_ROWS - 1)) ? '0
                                                                      : clr_row_reg + 1'b1;
            end
            else
            begin
                clr_col_next = clr_col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        case (cmd.wr_addr_sel)
            WA_CURSOR:      wr_addr = {cur_phys, col_reg};
            WA_CURSOR_LEFT: wr_addr = {cur_phys, col_reg - 1'b1};
            WA_SWEEP:       wr_addr = {cur_phys, clr_col_reg};
            WA_INIT:        wr_addr = {clr_row_reg, clr_col_reg};
            default:        wr_addr = {cur_phys, col_reg};
        endcase
    end

    assign wr_data = cmd.wr_char ? code : 8'd0;
    assign rd_addr = {phys_row(item_reg.read_row, top_reg), item_reg.read_col};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            top_reg     <= '0;
            clr_col_reg <= '0;
            clr_row_reg <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            top_reg     <= top_next;
            clr_col_reg <= clr_col_next;
            clr_row_reg <= clr_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.out_load)
        begin
            result_reg <= '{cell_char: rd_cell, cursor_row: row_next, cursor_col: col_next};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            grid_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= grid_mem[rd_addr];
        end
    end

    assign rd_cell = (stat.is_read && stat.read_ok) ? rd_data_reg : 8'd0;

    always_comb
    begin
        stat.is_read    = (item_reg.cmd == CMD_READ);
        stat.read_ok    = ({1'b0, item_reg.read_row} < (ROW_W+1)'(GRID_ROWS))
                          && (item_reg.read_col <= COL_W'(GRID_COLS));
        stat.ch_esc     = (code == CH_ESC);
        stat.ch_lbrack  = (code == CH_LBRACK);
        stat.ch_cr      = (code == CH_CR);
        stat.ch_lf      = (code == CH_LF);
        stat.ch_bs      = (code == CH_BS) || (code == CH_DEL);
        stat.ch_print   = (code >= PRINT_LO) && (code <= PRINT_HI);
        stat.ch_csi_end = ((code >= CH_UP_A) && (code <= CH_UP_Z))
                          || ((code >= CH_LO_A) && (code <= CH_LO_Z))
                          || (code == CH_TILDE);
        stat.col_zero   = (col_reg == '0);
        stat.col_full   = (col_reg >= COL_W'(GRID_COLS));
        stat.row_last   = (row_reg == ROW_W'(GRID_ROWS - 1));
        stat.sweep_col_last = (clr_col_reg == COL_W'(GRID_COLS));
        stat.sweep_row_last = (clr_row_reg == ROW_W'(GRID_ROWS - 1));
    end

    assign result = result_reg;

`ifndef SYNTH
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(GRID_COLS))
        else $error("Cursor column ran past the trailing cell.");

    a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, top_reg} < (ROW_W+1)'(GRID_ROWS))
        else $error("Ring top row is outside the grid.");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, row_reg} < (ROW_W+1)'(GRID_ROWS))
        else $error("Cursor row is outside the grid.");
`endif

endmodule

// ===== hdl/ttcg_ctrl.sv =====
module ttcg_ctrl
    import ttcg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    output logic      result_valid,
    input  logic      result_stall,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_PUT    = 3'd4;
    localparam logic [2:0] S_ZERO   = 3'd5;
    localparam logic [2:0] S_READ   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_CSI    = 2'd2;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       fin;

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg;
        fin            = 1'b0;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = WA_INIT;
                cmd.sweep_step  = 1'b1;
                if (stat.sweep_col_last && stat.sweep_row_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_read)
                begin
                    if (stat.read_ok)
                    begin
                        cmd.rd_en  = 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                else
                begin
                    case (mode_reg)
                        MODE_ESC:
                        begin
                            mode_next = stat.ch_lbrack ? MODE_CSI : MODE_NORMAL;
                            fin       = 1'b1;
                        end
                        MODE_CSI:
                        begin
                            if (stat.ch_csi_end)
                            begin
                                mode_next = MODE_NORMAL;
                            end
                            fin = 1'b1;
                        end
                        default:
                        begin
                            if (stat.ch_esc)
                            begin
                                mode_next = MODE_ESC;
                                fin       = 1'b1;
                            end
                            else if (stat.ch_cr)
                            begin
                                cmd.col_op = COL_ZERO;
                                fin        = 1'b1;
                            end
                            else if (stat.ch_lf)
                            begin
                                cmd.col_op = COL_ZERO;
                                if (stat.row_last)
                                begin
                                    cmd.scroll = 1'b1;
                                    state_next = S_SCROLL;
                                end
                                else
                                begin
                                    cmd.row_inc = 1'b1;
                                    fin         = 1'b1;
                                end
                            end
                            else if (stat.ch_bs)
                            begin
                                if (!stat.col_zero)
                                begin
                                    cmd.col_op      = COL_DEC;
                                    cmd.wr_en       = 1'b1;
                                    cmd.wr_addr_sel = WA_CURSOR_LEFT;
                                end
                                fin = 1'b1;
                            end
                            else if (stat.ch_print)
                            begin
                                if (stat.col_full)
                                begin
                                    cmd.col_op = COL_ZERO;
                                    if (stat.row_last)
                                    begin
                                        cmd.scroll = 1'b1;
                                        state_next = S_SCROLL;
                                    end
                                    else
                                    begin
                                        cmd.row_inc = 1'b1;
                                        state_next  = S_PUT;
                                    end
                                end
                                else
                                begin
                                    cmd.wr_en       = 1'b1;
                                    cmd.wr_addr_sel = WA_CURSOR;
                                    cmd.wr_char     = 1'b1;
                                    cmd.col_op      = COL_INC;
                                    state_next      = S_ZERO;
                                end
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_SCROLL:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = WA_SWEEP;
                cmd.sweep_step  = 1'b1;
                if (stat.sweep_col_last)
                begin
                    if (stat.ch_print)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            end
            S_PUT:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = WA_CURSOR;
                cmd.wr_char     = 1'b1;
                cmd.col_op      = COL_INC;
                state_next      = S_ZERO;
            end
            S_ZERO:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = WA_CURSOR;
                fin             = 1'b1;
            end
            S_READ:
            begin
                fin = 1'b1;
            end
            S_DONE:
            begin
                fin = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            if (out_free)
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            mode_reg      <= MODE_NORMAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

`ifndef SYNTH
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == S_EXEC))
        else $error("Accepted transaction did not enter execution.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !result_stall))
        else $error("Pending result overwritten before it was taken.");

    a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCROLL) |-> stat.row_last)
        else $error("Row clear sweep while cursor is not on the last row.");
`endif

endmodule

// ===== hdl/text_terminal_char_grid_top.sv =====
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     item   (cmd, char_code, read_row, read_col)
// result    out        result_valid / result_stall result (cell_char, cursor_row, cursor_col)
//
// Each transaction runs to completion before the next is taken; a printable byte also writes
// the zero after it, a wrapped printable first moves to the next row, and an in-range read
// uses a registered memory read. A line feed or wrap past the last row clears the new row,
// one cell a cycle. After reset GRID_ROWS*(GRID_COLS+1) cells (656) clear with item_stall high.
// A finished result waits in the output register while the next transaction is accepted;
// a transaction that finishes while that result is still stalled holds until it drains.

module text_terminal_char_grid_top
    import ttcg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    // The controller sequences escape parsing, cursor moves, grid writes and the
    // row clear sweeps; the datapath holds the cursor, the ring of grid rows and
    // the output register.
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    ttcg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Scrolling moves the ring's top row instead of copying the grid, so only
    // the newly exposed row needs clearing.
    ttcg_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule
